@@ rtl/core/wvc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_pkg
// Shared types, constants and CORDIC arctangent table for the waypoint
// velocity controller.
// ----------------------------------------------------------------------------
package wvc_pkg;

  localparam int CordicIterations = 16;
  localparam int AtanTableLen     = 24;

  localparam int CfgIndexWidth = 1;
  localparam int CfgDataWidth  = 15;

  localparam logic [CfgIndexWidth-1:0] CFG_ARRIVE_DISTANCE = 1'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_ROTATE_ONLY     = 1'd1;

  localparam logic [11:0] ArriveDistanceReset = 12'd300;
  localparam logic [14:0] RotateOnlyReset     = 15'd2458;

  // Datapath width inside the CORDIC cells
  localparam int CordicWidth = 36;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VECTOR,
    ST_ROTATE,
    ST_FINISH
  } wvc_state_t;

  // Mode and control handed along the cell chain
  typedef struct packed {
    logic run;
    logic rotate;
  } wvc_cell_ctrl_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/wvc_stream_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_stream_if
// Valid/ready channel carrying one payload of parameterized type.
// ----------------------------------------------------------------------------
interface wvc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/waypoint_velocity_controller.sv @@
`default_nettype none
// From input transfer to result valid: two passes through the CORDIC cell row,
// then multiply, combine, round.
// Empty path or arrival: result valid in the cycle after the input transfer.
// One item at a time: no new input is accepted while an item is in progress
// or while the output result has not yet been taken.
// Reset (rst, synchronous): clears history, registers to reset values, idle.
// ----------------------------------------------------------------------------
// waypoint_velocity_controller
// Heading error by CORDIC vectoring, force by CORDIC rotation, damped
// velocity commands and goal detection.
// ----------------------------------------------------------------------------
module waypoint_velocity_controller #(
  parameter int CORDIC_ITERATIONS = wvc_pkg::CordicIterations
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  wvc_stream_if.sink                                 in_ch,
  wvc_stream_if.source                               out_ch,
  input  wire logic                                  cfg_we,
  input  wire logic [wvc_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  wire logic [wvc_pkg::CfgDataWidth-1:0]      cfg_data
);
  import wvc_pkg::*;

  // payload layout: wx, wy, rx, ry, heading, last, empty
  // out layout: lin_vel(13), ang_vel(14), goal(1)

  wvc_state_t state, state_next;

  logic [11:0] arrive_distance_mm;
  logic [14:0] rotate_only_angle;
  logic [12:0] last_lin_vel;
  logic signed [13:0] last_ang_vel;

  logic        is_last;
  logic signed [15:0] heading;
  logic [31:0] err_bam;
  logic        out_valid;
  logic [12:0] lin_res;
  logic signed [13:0] ang_res;
  logic        goal_res;

  logic        cs_start, cs_rotate, c_done;
  logic signed [CordicWidth-1:0] cx_in, cy_in, cx_out, cy_out;
  logic signed [32:0] cz_in, cz_out;

  logic [1:0]  fin_step;
  logic signed [CordicWidth-1:0] fx, fy;
  logic signed [63:0] pv, pw, qv, qw;

  wire logic [15:0] in_wx = in_ch.data[81:66];
  wire logic [15:0] in_wy = in_ch.data[65:50];
  wire logic [15:0] in_rx = in_ch.data[49:34];
  wire logic [15:0] in_ry = in_ch.data[33:18];
  wire logic [15:0] in_hd = in_ch.data[17:2];
  wire logic        in_last  = in_ch.data[1];
  wire logic        in_empty = in_ch.data[0];

  logic in_fire;
  assign in_ch.ready = (state == ST_IDLE) && !out_valid;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrive_distance_mm <= ArriveDistanceReset;
      rotate_only_angle  <= RotateOnlyReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ARRIVE_DISTANCE: arrive_distance_mm <= cfg_data[11:0];
        CFG_ROTATE_ONLY:     rotate_only_angle  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [16:0] ndx, ndy;
  logic [33:0] nd2;
  assign ndx = 17'(signed'(in_wx)) - 17'(signed'(in_rx));
  assign ndy = 17'(signed'(in_wy)) - 17'(signed'(in_ry));
  assign nd2 = 34'(ndx * ndx) + 34'(ndy * ndy);

  logic in_arrive, zero_off;
  assign in_arrive = in_last && (nd2 < 34'(arrive_distance_mm * arrive_distance_mm));
  assign zero_off  = (ndx == 0) && (ndy == 0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire && !in_empty && !in_arrive) state_next = ST_VECTOR;
      ST_VECTOR: if (c_done) state_next = ST_ROTATE;
      ST_ROTATE: if (c_done) state_next = ST_FINISH;
      ST_FINISH: if (fin_step == 2'd2) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  logic zero_bearing;
  logic [31:0] head_bam;
  assign head_bam = 32'(signed'(heading) * 32'sd166886);

  // CORDIC launch
  logic launch_vec, launch_rot;
  logic [31:0] rot_ang;
  logic        rot_flip;
  assign launch_vec = in_fire && !in_empty && !in_arrive;
  assign launch_rot = (state == ST_VECTOR) && c_done;

  logic [31:0] bearing_v;
  assign bearing_v = zero_bearing ? 32'd0 : cz_out[31:0];
  logic [31:0] e_now;
  assign e_now = bearing_v - head_bam;
  logic signed [32:0] e_s;
  assign e_s = 33'(signed'(e_now));
  assign rot_flip = (e_s > 33'sh40000000) || (e_s < -33'sh40000000);
  assign rot_ang  = rot_flip ? e_now - 32'h80000000 : e_now;

  always_comb begin
    cs_start  = launch_vec || launch_rot;
    cs_rotate = launch_rot;
    if (launch_rot) begin
      cx_in = rot_flip ? -CordicWidth'(489024660) : CordicWidth'(489024660);
      cy_in = '0;
      cz_in = 33'(signed'(rot_ang));
    end else if (ndx < 0) begin
      cx_in = -(CordicWidth'(ndx) <<< 14);
      cy_in = -(CordicWidth'(ndy) <<< 14);
      cz_in = 33'sh080000000;
    end else begin
      cx_in = CordicWidth'(ndx) <<< 14;
      cy_in = CordicWidth'(ndy) <<< 14;
      cz_in = '0;
    end
  end

  wvc_cordic_chain #(.Iterations(CORDIC_ITERATIONS)) u_chain (
    .clk(clk), .rst(rst), .start(cs_start), .rotate(cs_rotate),
    .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
    .done(c_done), .x_out(cx_out), .y_out(cy_out), .z_out(cz_out)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      heading <= signed'(in_hd); is_last <= in_last;
      zero_bearing <= zero_off;
    end
    if (launch_rot) err_bam <= e_now;
    if ((state == ST_ROTATE) && c_done) begin
      fx <= cx_out; fy <= cy_out;
    end
  end

  // finish: step 0 multiply, step 1 combine, step 2 round and write
  logic [31:0] aerr_bam;
  logic [49:0] aerr_prod;
  logic [14:0] aerr_q;
  assign aerr_bam  = err_bam[31] ? (~err_bam + 32'd1) : err_bam;
  assign aerr_prod = 50'(aerr_bam) * 50'd411775;
  assign aerr_q    = 15'((aerr_prod + 50'h400000000) >> 35);

  logic signed [63:0] nv, nw;
  logic signed [63:0] rv, rw;
  logic [12:0] v_fin;
  logic signed [13:0] w_fin;
  logic signed [15:0] gsum;
  assign rv = (nv + 64'sh800000000) >>> 36;
  assign rw = (nw + 64'sh800000000) >>> 36;

  always_comb begin
    if (nv < 0) v_fin = '0;
    else if (rv > 64'sd4096) v_fin = 13'd4096;
    else v_fin = 13'(rv);
    if (aerr_q > rotate_only_angle) v_fin = '0;
    if ((nw > -64'sh1000000000) && (nw < 64'sh1000000000)) w_fin = '0;
    else if (rw > 64'sd8191) w_fin = 14'sd8191;
    else if (rw < -64'sd8192) w_fin = -14'sd8192;
    else w_fin = 14'(rw);
    gsum = 16'(last_lin_vel) + 16'(v_fin) + 16'(last_ang_vel) + 16'(w_fin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_step <= '0;
    end else if (state == ST_FINISH) begin
      fin_step <= (fin_step == 2'd2) ? 2'd0 : fin_step + 2'd1;
    end
    if (state == ST_FINISH && fin_step == 2'd0) begin
      pv <= 64'(fx) * 64'sd117159;
      pw <= 64'(fy) * 64'sd233316;
      qv <= 64'(signed'({1'b0, last_lin_vel})) * 64'sd38390792192;
      qw <= 64'(last_ang_vel) * 64'sd39257047040;
    end
    if (state == ST_FINISH && fin_step == 2'd1) begin
      nv <= pv + qv;
      nw <= pw + qw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_lin_vel <= '0;
      last_ang_vel <= '0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (in_fire && (in_empty || in_arrive)) begin
        out_valid    <= 1'b1;
        lin_res      <= '0;
        ang_res      <= '0;
        goal_res     <= !in_empty;
        last_lin_vel <= '0;
        last_ang_vel <= '0;
      end else if (state == ST_FINISH && fin_step == 2'd2) begin
        out_valid    <= 1'b1;
        lin_res      <= v_fin;
        ang_res      <= w_fin;
        goal_res     <= is_last && (gsum <= 0);
        last_lin_vel <= v_fin;
        last_ang_vel <= w_fin;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = {lin_res, ang_res, goal_res};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_lin_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lin_res <= 13'd4096)) else $error("lin_vel over limit");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_empty) |=> (lin_res == 0 && ang_res == 0 && !goal_res))
    else $error("empty path not zeroed");

endmodule
`default_nettype wire

@@ rtl/core/wvc_cordic_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_cordic_cell
// One CORDIC micro-rotation stage with a fixed shift. Registers x, y, z and
// hands them to the next cell every cycle.
// ----------------------------------------------------------------------------
module wvc_cordic_cell #(
  parameter int Stage = 0
) (
  input  wire logic                               clk,
  input  wire wvc_pkg::wvc_cell_ctrl_t            ctrl_in,
  input  wire logic signed [wvc_pkg::CordicWidth-1:0] x_in,
  input  wire logic signed [wvc_pkg::CordicWidth-1:0] y_in,
  input  wire logic signed [32:0]                 z_in,
  output wvc_pkg::wvc_cell_ctrl_t                 ctrl_out,
  output logic signed [wvc_pkg::CordicWidth-1:0]  x_out,
  output logic signed [wvc_pkg::CordicWidth-1:0]  y_out,
  output logic signed [32:0]                      z_out
);
  import wvc_pkg::*;

  localparam logic [4:0] StageIdx = 5'(Stage);

  logic                          dir_pos;
  logic signed [CordicWidth-1:0] xs;
  logic signed [CordicWidth-1:0] ys;
  logic signed [32:0]            angle;

  always_comb begin
    // vectoring drives y to zero, rotation drives z to zero
    dir_pos = ctrl_in.rotate ? (z_in >= 0) : !(y_in > 0);
    xs      = x_in >>> Stage;
    ys      = y_in >>> Stage;
    angle   = signed'({1'b0, atan_bam(StageIdx)});
  end

  always_ff @(posedge clk) begin
    ctrl_out <= ctrl_in;
    if (dir_pos) begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - angle;
    end else begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + angle;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/wvc_cordic_chain.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wvc_cordic_chain
// Row of CORDIC cells, one per iteration, shared by the bearing and the
// force computation. A vector enters once and passes through each cell in turn.
// ----------------------------------------------------------------------------
module wvc_cordic_chain #(
  parameter int Iterations = wvc_pkg::CordicIterations
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic                                   rotate,
  input  wire logic signed [wvc_pkg::CordicWidth-1:0] x_in,
  input  wire logic signed [wvc_pkg::CordicWidth-1:0] y_in,
  input  wire logic signed [32:0]                     z_in,
  output logic                                        done,
  output logic signed [wvc_pkg::CordicWidth-1:0]      x_out,
  output logic signed [wvc_pkg::CordicWidth-1:0]      y_out,
  output logic signed [32:0]                          z_out
);
  import wvc_pkg::*;

  wvc_cell_ctrl_t                ctrl [Iterations+1];
  logic signed [CordicWidth-1:0] xv   [Iterations+1];
  logic signed [CordicWidth-1:0] yv   [Iterations+1];
  logic signed [32:0]            zv   [Iterations+1];
  logic [Iterations-1:0]         run_pipe;

  always_comb begin
    ctrl[0].run    = start;
    ctrl[0].rotate = rotate;
    xv[0]          = x_in;
    yv[0]          = y_in;
    zv[0]          = z_in;
  end

  for (genvar i = 0; i < Iterations; i++) begin : g_cell
    wvc_cordic_cell #(.Stage(i)) u_cell (
      .clk      (clk),
      .ctrl_in  (ctrl[i]),
      .x_in     (xv[i]),
      .y_in     (yv[i]),
      .z_in     (zv[i]),
      .ctrl_out (ctrl[i+1]),
      .x_out    (xv[i+1]),
      .y_out    (yv[i+1]),
      .z_out    (zv[i+1])
    );
  end

  // valid tokens travel beside the cells with a clearing reset
  always_ff @(posedge clk) begin
    if (rst) begin
      run_pipe <= '0;
    end else begin
      run_pipe <= {run_pipe[Iterations-2:0], start};
    end
  end

  assign done  = run_pipe[Iterations-1] && ctrl[Iterations].run;
  assign x_out = xv[Iterations];
  assign y_out = yv[Iterations];
  assign z_out = zv[Iterations];

endmodule
`default_nettype wire
